/* sv/fcpa_pkg.sv */
`default_nettype none

package fcpa_pkg;

    typedef logic [1:0]  t_kind;
    typedef logic [7:0]  t_cidx;
    typedef logic [1:0]  t_status;
    typedef logic [31:0] t_addr;
    typedef logic [15:0] t_bytes;
    typedef logic [8:0]  t_count;
    typedef logic [1:0]  t_cfg_index;
    typedef logic [2:0]  t_opcode;

    localparam t_kind KIND_ALLOC    = 2'd0;
    localparam t_kind KIND_FREE     = 2'd1;
    localparam t_kind KIND_FREE_ALL = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_RANGE = 2'd2;

    localparam t_cfg_index CFG_BASE_ADDRESS = 2'd0;
    localparam t_cfg_index CFG_CHUNK_BYTES  = 2'd1;
    localparam t_cfg_index CFG_CHUNK_COUNT  = 2'd2;

    localparam t_addr  BASE_ADDRESS_RST = 32'd0;
    localparam t_bytes CHUNK_BYTES_RST  = 16'd16;
    localparam t_count CHUNK_COUNT_RST  = 9'd256;

    localparam t_opcode OP_ALLOC    = 3'd0;
    localparam t_opcode OP_FREE     = 3'd1;
    localparam t_opcode OP_REJECT   = 3'd2;
    localparam t_opcode OP_FREE_ALL = 3'd3;
    localparam t_opcode OP_NOP      = 3'd4;

    typedef struct packed {
        t_opcode code;
        t_cidx   idx;
    } t_op;

    typedef struct packed {
        t_status status;
        t_cidx   given_index;
        t_addr   given_address;
    } t_rsp;

endpackage

`default_nettype wire

/* sv/fcpa_in_if.sv */
`default_nettype none

interface fcpa_in_if;
    import fcpa_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_cidx chunk_index;

    modport source (output valid, output kind, output chunk_index, input ready);
    modport sink (input valid, input kind, input chunk_index, output ready);
endinterface

`default_nettype wire

/* sv/fcpa_out_if.sv */
`default_nettype none

interface fcpa_out_if;
    import fcpa_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_cidx   given_index;
    t_addr   given_address;

    modport source (output valid, output status, output given_index, output given_address,
                    input ready);
    modport sink (input valid, input status, input given_index, input given_address,
                  output ready);
endinterface

`default_nettype wire

/* sv/fixed_chunk_pool_allocator.sv */
// Pool allocator for equal-sized chunks, kept on a last-in first-out free list.
// Requests arrive on i_req (kind, chunk_index) and each one produces exactly one
// response on o_rsp (status, given_index, given_address), in request order.
// Configuration registers (base address, chunk size, chunk count) are written
// through i_cfg_we, i_cfg_index and i_cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. A transfer
// on i_req enters a two-entry queue, so up to two requests are taken while the
// engine is busy or the response waits. The engine holds the link store in a
// single-port-read memory. It can take one free, rejected free or unused kind
// per cycle while o_rsp is not stalled. An alloc on a non-empty list reads the
// link of the head from the memory and responds from the alloc state, taking no
// request meanwhile. A free-all walks every chunk below the effective count, one
// link write per cycle. Reset clears the queue and the response register and
// then runs the same walk over min(256, NUM_CHUNKS) chunks; requests are queued
// but not executed until it ends. A stalled o_rsp holds the response; the
// engine then stops and the queue fills, after which i_req.ready drops.
`default_nettype none

module fixed_chunk_pool_allocator #(
    parameter int NUM_CHUNKS = 256
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    fcpa_in_if.sink                i_req,
    fcpa_out_if.source             o_rsp,
    input  wire                    i_cfg_we,
    input  fcpa_pkg::t_cfg_index   i_cfg_index,
    input  wire [31:0]             i_cfg_data
);
    import fcpa_pkg::*;

    localparam int LW = $clog2(NUM_CHUNKS) + 1;
    localparam int CW = (LW > 9) ? LW : 9;

    t_addr         r_base;
    t_bytes        r_chunk_bytes;
    t_count        r_chunk_count;
    logic [LW-1:0] w_eff_count;
    logic          w_q_valid;
    t_op           w_q_op;
    logic          w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= BASE_ADDRESS_RST;
            r_chunk_bytes <= CHUNK_BYTES_RST;
            r_chunk_count <= CHUNK_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDRESS: r_base        <= i_cfg_data;
                CFG_CHUNK_BYTES:  r_chunk_bytes <= i_cfg_data[15:0];
                CFG_CHUNK_COUNT:  r_chunk_count <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign w_eff_count = (CW'(r_chunk_count) > CW'(NUM_CHUNKS)) ? LW'(NUM_CHUNKS)
                                                                 : LW'(r_chunk_count);

    fcpa_front #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_eff_count (w_eff_count),
        .i_pop       (w_q_pop),
        .o_q_valid   (w_q_valid),
        .o_q_op      (w_q_op)
    );

    fcpa_back #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_op        (w_q_op),
        .o_q_pop       (w_q_pop),
        .i_base        (r_base),
        .i_chunk_bytes (r_chunk_bytes),
        .i_eff_count   (w_eff_count),
        .o_rsp         (o_rsp)
    );

endmodule

`default_nettype wire

/* sv/fcpa_front.sv */
`default_nettype none

module fcpa_front #(
    parameter int  NUM_CHUNKS = 256,
    localparam int LW         = $clog2(NUM_CHUNKS) + 1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    fcpa_in_if.sink          i_req,
    input  wire [LW-1:0]     i_eff_count,
    input  wire              i_pop,
    output logic             o_q_valid,
    output fcpa_pkg::t_op    o_q_op
);
    import fcpa_pkg::*;

    localparam int CW = (LW > 8) ? LW : 8;

    t_op        r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic       w_push;
    t_op        w_op;

    assign i_req.ready = (r_fill != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_fill != 2'd0);
    assign o_q_op      = r_q[r_rd_ptr];

    always_comb begin
        w_op.idx = i_req.chunk_index;
        unique case (i_req.kind)
            KIND_ALLOC: begin
                w_op.code = OP_ALLOC;
            end
            KIND_FREE: begin
                w_op.code = (CW'(i_req.chunk_index) >= CW'(i_eff_count)) ? OP_REJECT : OP_FREE;
            end
            KIND_FREE_ALL: begin
                w_op.code = OP_FREE_ALL;
            end
            default: begin
                w_op.code = OP_NOP;
            end
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (w_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!w_push && i_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_op;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_fill != 2'd0))
        else $error("queue popped while empty");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2)
        else $error("queue fill count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fill == 2'd0) || (r_fill == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

/* sv/fcpa_back.sv */
`default_nettype none

module fcpa_back #(
    parameter int  NUM_CHUNKS = 256,
    localparam int IW         = $clog2(NUM_CHUNKS),
    localparam int LW         = IW + 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_valid,
    input  fcpa_pkg::t_op        i_q_op,
    output logic                 o_q_pop,
    input  fcpa_pkg::t_addr      i_base,
    input  fcpa_pkg::t_bytes     i_chunk_bytes,
    input  wire [LW-1:0]         i_eff_count,
    fcpa_out_if.source           o_rsp
);
    import fcpa_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    localparam int          RST_N   = (NUM_CHUNKS < 256) ? NUM_CHUNKS : 256;
    localparam logic [LW-1:0] NO_LINK = LW'(NUM_CHUNKS);

    logic [LW-1:0] r_links [NUM_CHUNKS];

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [LW-1:0] r_head;
    logic [LW-1:0] n_head;
    logic [LW-1:0] r_cnt;
    logic [LW-1:0] n_cnt;
    logic [LW-1:0] r_walk_n;
    logic [LW-1:0] n_walk_n;
    logic          r_silent;
    logic          n_silent;
    logic [LW-1:0] r_rd_link;
    logic [31:0]   r_prod;
    logic          r_out_valid;
    t_rsp          r_out;

    logic          w_pop;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [LW-1:0] w_wdata;
    logic          w_re;
    logic          w_res_load;
    t_rsp          w_res;

    assign w_pop   = (r_state == ST_IDLE) && i_q_valid && (!r_out_valid || o_rsp.ready);
    assign o_q_pop = w_pop;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.given_index   = r_out.given_index;
    assign o_rsp.given_address = r_out.given_address;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_walk_n   = r_walk_n;
        n_silent   = r_silent;
        w_we       = 1'b0;
        w_waddr    = r_cnt[IW-1:0];
        w_wdata    = r_head;
        w_re       = 1'b0;
        w_res_load = 1'b0;
        w_res      = '{status: STATUS_OK, given_index: '0, given_address: '0};
        unique case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    unique case (i_q_op.code)
                        OP_ALLOC: begin
                            if (r_head == NO_LINK) begin
                                w_res_load   = 1'b1;
                                w_res.status = STATUS_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                n_state = ST_ALLOC;
                            end
                        end
                        OP_FREE: begin
                            w_we       = 1'b1;
                            w_waddr    = IW'(i_q_op.idx);
                            n_head     = LW'(i_q_op.idx);
                            w_res_load = 1'b1;
                        end
                        OP_REJECT: begin
                            w_res_load   = 1'b1;
                            w_res.status = STATUS_RANGE;
                        end
                        OP_FREE_ALL: begin
                            n_head   = NO_LINK;
                            n_cnt    = '0;
                            n_walk_n = i_eff_count;
                            n_silent = 1'b0;
                            n_state  = ST_WALK;
                        end
                        default: begin
                            w_res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                n_head              = r_rd_link;
                w_res_load          = 1'b1;
                w_res.given_index   = 8'(r_head[IW-1:0]);
                w_res.given_address = i_base + r_prod;
                n_state             = ST_IDLE;
            end
            ST_WALK: begin
                if (r_cnt == r_walk_n) begin
                    w_res_load = !r_silent;
                    n_state    = ST_IDLE;
                end else begin
                    w_we   = 1'b1;
                    n_head = r_cnt;
                    n_cnt  = LW'(r_cnt + 1'b1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WALK;
            r_head      <= NO_LINK;
            r_cnt       <= '0;
            r_walk_n    <= LW'(RST_N);
            r_silent    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_cnt    <= n_cnt;
            r_walk_n <= n_walk_n;
            r_silent <= n_silent;
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 32'(r_head[IW-1:0] * i_chunk_bytes);
        if (w_res_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_links[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_link <= r_links[r_head[IW-1:0]];
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (!r_out_valid || o_rsp.ready))
        else $error("result register overwritten before transfer");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= NO_LINK)
        else $error("free list head out of range");

    a_alloc_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |=> (r_state == ST_IDLE))
        else $error("alloc lookup did not complete in one cycle");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cnt <= r_walk_n))
        else $error("rebuild walk passed its end");

endmodule

`default_nettype wire

/* dv/fcpa_checker.sv */
`default_nettype none

module fcpa_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    fcpa_in_if                   i_req,
    fcpa_out_if                  i_rsp,
    input  wire                  i_cfg_we,
    input  fcpa_pkg::t_cfg_index i_cfg_index,
    input  wire [31:0]           i_cfg_data,
    input  wire                  i_end_check,
    output int                   o_fail_count,
    output int                   o_pending
);
    import fcpa_pkg::*;

    localparam int         POOL_SLOTS = 256;
    localparam logic [8:0] NO_LINK    = 9'd256;

    logic [8:0] link_mem [POOL_SLOTS];
    logic [8:0] head;
    t_addr      base;
    t_bytes     bytes;
    t_count     count;
    t_rsp       owed_q [$];

    function automatic logic [8:0] live_count();
        return (count > 9'd256) ? 9'd256 : count;
    endfunction

    function automatic void refill_pool();
        logic [8:0] n;
        n = live_count();
        head = NO_LINK;
        for (int k = 0; k < n; k++) begin
            link_mem[k] = head;
            head = k[8:0];
        end
    endfunction

    function automatic void restart_pool();
        base  = BASE_ADDRESS_RST;
        bytes = CHUNK_BYTES_RST;
        count = CHUNK_COUNT_RST;
        foreach (link_mem[k]) begin
            link_mem[k] = '0;
        end
        refill_pool();
    endfunction

    function automatic t_rsp serve(t_kind k, t_cidx c);
        t_rsp       r;
        logic [8:0] h;
        r = '0;
        case (k)
            KIND_ALLOC: begin
                if (head >= NO_LINK) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    h = head;
                    head = link_mem[h[7:0]];
                    r.given_index = h[7:0];
                    r.given_address = base + t_addr'(h) * t_addr'(bytes);
                end
            end
            KIND_FREE: begin
                if ({1'b0, c} >= live_count()) begin
                    r.status = STATUS_RANGE;
                end else begin
                    link_mem[c] = head;
                    head = {1'b0, c};
                end
            end
            KIND_FREE_ALL: begin
                refill_pool();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp owed;
        if (!i_rst_n) begin
            restart_pool();
            owed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_ADDRESS: base  = i_cfg_data;
                    CFG_CHUNK_BYTES:  bytes = i_cfg_data[15:0];
                    CFG_CHUNK_COUNT:  count = i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                owed_q.push_back(serve(i_req.kind, i_req.chunk_index));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_q.size() == 0) begin
                    $error("Response transfer arrived with no request outstanding.");
                    o_fail_count++;
                end else begin
                    owed = owed_q.pop_front();
                    check_field("status", 32'(owed.status), 32'(i_rsp.status));
                    check_field("given_index", 32'(owed.given_index), 32'(i_rsp.given_index));
                    check_field("given_address", owed.given_address, i_rsp.given_address);
                end
            end
            if (i_end_check) begin
                foreach (owed_q[k]) begin
                    $error("status: expected %0d, got no response", owed_q[k].status);
                end
                o_fail_count += owed_q.size();
                owed_q.delete();
            end
        end
        o_pending = owed_q.size();
    end

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;
    import fcpa_pkg::*;

    localparam t_kind KIND_UNUSED   = 2'd3;
    localparam int    WALK_CYCLES   = 300;
    localparam int    PHASE_ITEMS   = 50;
    localparam int    RANDOM_PHASES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_index  cfg_index;
    logic [31:0] cfg_data;
    logic        end_check;
    int          fails;
    int          pending;
    int          span;
    bit          idling = 1'b1;

    fcpa_in_if  req_if ();
    fcpa_out_if rsp_if ();

    fixed_chunk_pool_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fcpa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_end_check  (end_check),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        rsp_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_req(t_kind k, t_cidx c);
        req_if.valid       <= 1'b1;
        req_if.kind        <= k;
        req_if.chunk_index <= c;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (idling && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Every response has been taken before the pause, so the engine is idle
    // when the configuration changes.
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (WALK_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_pool(t_addr b, t_bytes sz, t_count n);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_ADDRESS;
        cfg_data  <= b;
        @(posedge i_clk);
        cfg_index <= CFG_CHUNK_BYTES;
        cfg_data  <= {16'd0, sz};
        @(posedge i_clk);
        cfg_index <= CFG_CHUNK_COUNT;
        cfg_data  <= {23'd0, n};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        span = (n > 9'd256) ? 256 : int'(n);
    endtask

    initial begin
        t_count n;
        t_addr  b;
        t_bytes sz;
        int     sent;
        int     pick;
        int     burst;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_BASE_ADDRESS;
        cfg_data           <= '0;
        end_check          <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.kind        <= KIND_ALLOC;
        req_if.chunk_index <= '0;
        span = 256;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (WALK_CYCLES) @(posedge i_clk);

        // Pool as left by reset, then a double free and an unused kind.
        send_req(KIND_ALLOC, 8'd0);
        send_req(KIND_ALLOC, 8'd255);
        send_req(KIND_FREE, 8'd255);
        send_req(KIND_FREE, 8'd0);
        send_req(KIND_UNUSED, 8'd255);
        send_req(KIND_FREE_ALL, 8'd0);
        send_req(KIND_ALLOC, 8'd0);

        // Tiny pool with the widest chunks, so addresses wrap, and drained.
        program_pool(32'hFFFF_FF00, 16'hFFFF, 9'd3);
        send_req(KIND_FREE_ALL, 8'd0);
        repeat (4) send_req(KIND_ALLOC, 8'd0);
        send_req(KIND_FREE, 8'd3);
        send_req(KIND_FREE, 8'd255);
        send_req(KIND_FREE, 8'd1);
        send_req(KIND_FREE, 8'd2);
        repeat (3) send_req(KIND_ALLOC, 8'd0);
        send_req(KIND_FREE, 8'd0);
        send_req(KIND_ALLOC, 8'd0);

        // A count of zero: the old list stays until a free-all empties it.
        program_pool(32'd0, 16'd1, 9'd0);
        send_req(KIND_ALLOC, 8'd0);
        send_req(KIND_FREE_ALL, 8'd0);
        send_req(KIND_ALLOC, 8'd0);
        send_req(KIND_FREE, 8'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    n = 9'd1;
                    sz = 16'd1;
                    b = 32'd0;
                end
                1: begin
                    n = 9'd256;
                    sz = 16'hFFFF;
                    b = 32'hFFFF_FFFF;
                end
                2: begin
                    n = 9'd511;
                    sz = t_bytes'($urandom_range(1, 65535));
                    b = $urandom;
                end
                default: begin
                    n = ($urandom_range(0, 4) == 0) ? t_count'($urandom_range(1, 256))
                                                    : t_count'($urandom_range(2, 12));
                    sz = ($urandom_range(0, 1) == 0) ? t_bytes'($urandom_range(1, 64))
                                                     : t_bytes'($urandom_range(1, 65535));
                    b = $urandom;
                end
            endcase
            idling = (p != 4) && (p != RANDOM_PHASES - 1);
            program_pool(b, sz, n);
            if ($urandom_range(0, 3) != 0) begin
                send_req(KIND_FREE_ALL, t_cidx'($urandom));
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                burst = (pick < 4) ? $urandom_range(1, 16) : $urandom_range(1, 6);
                if (pick == 7) begin
                    burst = 1;
                end
                for (int j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
                    if (pick < 4) begin
                        send_req(KIND_ALLOC, t_cidx'($urandom));
                    end else if (pick < 7) begin
                        send_req(KIND_FREE,
                                 (span > 0 && $urandom_range(0, 5) != 0)
                                     ? t_cidx'($urandom_range(0, span - 1))
                                     : t_cidx'($urandom));
                    end else if (pick == 7) begin
                        send_req(KIND_FREE_ALL, t_cidx'($urandom));
                    end else begin
                        send_req(t_kind'($urandom_range(0, 3)), t_cidx'($urandom));
                    end
                    sent++;
                end
            end
        end

        settle();
        end_check <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        if (fails == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
